// ===== hdl/vicf_pkg.sv =====
// ----------------------------------------------------------------------------
// vicf_pkg
// Shared types and constants of the VISCA-over-IP command framer.
// ----------------------------------------------------------------------------
`default_nettype none

package vicf_pkg;

   // operation codes on the request channel
   localparam logic [1:0] OP_APPLY = 2'd0;
   localparam logic [1:0] OP_HOME  = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_LINK_ENABLE = 2'd0;
   localparam logic [1:0] CSR_PAN_SPEED   = 2'd1;
   localparam logic [1:0] CSR_TILT_SPEED  = 2'd2;

   localparam int CSR_DATA_W = 5;

   // clamp limits, tenths of a degree
   localparam logic signed [11:0] PAN_MAX  = 12'sd1700;
   localparam logic signed [11:0] PAN_MIN  = -12'sd1700;
   localparam logic signed [10:0] TILT_MAX = 11'sd900;
   localparam logic signed [10:0] TILT_MIN = -11'sd300;
   localparam logic [16:0]        ZOOM_MAX = 17'd65536;

   // position = floor((t*144 + 50) / 100), biased to stay non-negative
   localparam logic signed [20:0] ANGLE_GAIN = 21'sd144;
   localparam logic signed [20:0] ANGLE_BIAS = 21'sd300050;
   localparam logic [20:0]        RECIP_100  = 21'd1342178; // ceil(2^27 / 100)
   localparam int                 RECIP_SHIFT = 27;
   localparam logic [15:0]        POS_OFFSET = 16'd3000;

   // speed ranges
   localparam logic [4:0] PAN_SPEED_MAX  = 5'd24;
   localparam logic [4:0] TILT_SPEED_MAX = 5'd20;
   localparam logic [4:0] SPEED_MIN      = 5'd1;

   // datagram bytes
   localparam logic [7:0] HDR_TYPE_HI   = 8'h01;
   localparam logic [7:0] HDR_TYPE_LO   = 8'h00;
   localparam logic [7:0] VISCA_ADDR    = 8'h81;
   localparam logic [7:0] VISCA_COMMAND = 8'h01;
   localparam logic [7:0] CAT_PAN_TILT  = 8'h06;
   localparam logic [7:0] CAT_CAMERA    = 8'h04;
   localparam logic [7:0] CMD_ABS_POS   = 8'h02;
   localparam logic [7:0] CMD_HOME_POS  = 8'h04;
   localparam logic [7:0] CMD_DRIVE     = 8'h01;
   localparam logic [7:0] CMD_ZOOM_DIR  = 8'h47;
   localparam logic [7:0] DRIVE_HOLD    = 8'h03;
   localparam logic [7:0] VISCA_TERM    = 8'hff;

   localparam int HDR_LEN = 8;
   localparam logic [4:0] LEN_PANTILT = 5'd15;
   localparam logic [4:0] LEN_ZOOM    = 5'd9;
   localparam logic [4:0] LEN_HOME    = 5'd5;
   localparam logic [4:0] LEN_STOP    = 5'd9;

   typedef enum logic [1:0] {
      CMD_APPLY,
      CMD_HOME,
      CMD_STOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  pan_pos;
      logic [15:0]  tilt_pos;
      logic [14:0]  zoom_pos;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PANTILT,
      ST_ZOOM,
      ST_HOME,
      ST_STOP
   } back_state_type;

endpackage

`default_nettype wire

// ===== hdl/vicf_front.sv =====
// ----------------------------------------------------------------------------
// vicf_front
// Accepts requests, drops those that emit nothing, clamps the angles and
// zoom and converts them to VISCA positions, scaling before its register, dividing after.
// ----------------------------------------------------------------------------
`default_nettype none

module vicf_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                link_enable,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [1:0]          req_operation,
   input  wire logic                req_send_request,
   input  wire logic signed [11:0]  req_pan_angle,
   input  wire logic signed [10:0]  req_tilt_angle,
   input  wire logic [16:0]         req_zoom_level,
   output      logic                cmd_valid,
   input  wire logic                cmd_ready,
   output      vicf_pkg::cmd_type   cmd_data
);

   logic                   a_valid_ff, a_valid_in;
   vicf_pkg::cmd_kind_type a_kind_ff, kind;
   logic [19:0]            a_vpan_ff, a_vtilt_ff;
   logic [14:0]            a_zoom_ff;

   logic                   wanted, load;
   logic signed [11:0]     pan_c;
   logic signed [10:0]     tilt_c;
   logic [16:0]            zoom_c;
   logic [17:0]            zoom_round;
   logic signed [20:0]     vpan, vtilt;
   logic [40:0]            pan_prod, tilt_prod;

   always_comb begin
      wanted = 1'b0;
      kind   = vicf_pkg::CMD_APPLY;
      unique case (req_operation)
         vicf_pkg::OP_APPLY: begin
            wanted = req_send_request;
            kind   = vicf_pkg::CMD_APPLY;
         end
         vicf_pkg::OP_HOME: begin
            wanted = 1'b1;
            kind   = vicf_pkg::CMD_HOME;
         end
         vicf_pkg::OP_STOP: begin
            wanted = 1'b1;
            kind   = vicf_pkg::CMD_STOP;
         end
         default: begin
            wanted = 1'b0;
            kind   = vicf_pkg::CMD_APPLY;
         end
      endcase
   end

   assign req_ready = !a_valid_ff || cmd_ready;
   assign load      = req_valid && req_ready && link_enable && wanted;

   always_comb begin
      if (req_pan_angle > vicf_pkg::PAN_MAX) begin
         pan_c = vicf_pkg::PAN_MAX;
      end else if (req_pan_angle < vicf_pkg::PAN_MIN) begin
         pan_c = vicf_pkg::PAN_MIN;
      end else begin
         pan_c = req_pan_angle;
      end
      if (req_tilt_angle > vicf_pkg::TILT_MAX) begin
         tilt_c = vicf_pkg::TILT_MAX;
      end else if (req_tilt_angle < vicf_pkg::TILT_MIN) begin
         tilt_c = vicf_pkg::TILT_MIN;
      end else begin
         tilt_c = req_tilt_angle;
      end
      zoom_c = (req_zoom_level > vicf_pkg::ZOOM_MAX) ? vicf_pkg::ZOOM_MAX : req_zoom_level;
   end

   assign vpan       = 21'(pan_c) * vicf_pkg::ANGLE_GAIN + vicf_pkg::ANGLE_BIAS;
   assign vtilt      = 21'(tilt_c) * vicf_pkg::ANGLE_GAIN + vicf_pkg::ANGLE_BIAS;
   assign zoom_round = {1'b0, zoom_c} + 18'd2;

   assign a_valid_in = load ? 1'b1 : (cmd_ready ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_kind_ff  <= kind;
         a_vpan_ff  <= vpan[19:0];
         a_vtilt_ff <= vtilt[19:0];
         a_zoom_ff  <= zoom_round[16:2];
      end
   end

   // divide by 100 through the reciprocal, exact over the biased range
   assign pan_prod  = 41'(a_vpan_ff) * 41'(vicf_pkg::RECIP_100);
   assign tilt_prod = 41'(a_vtilt_ff) * 41'(vicf_pkg::RECIP_100);

   assign cmd_valid         = a_valid_ff;
   assign cmd_data.kind     = a_kind_ff;
   assign cmd_data.pan_pos  = {2'b00, pan_prod[40:vicf_pkg::RECIP_SHIFT]}
                              - vicf_pkg::POS_OFFSET;
   assign cmd_data.tilt_pos = {2'b00, tilt_prod[40:vicf_pkg::RECIP_SHIFT]}
                              - vicf_pkg::POS_OFFSET;
   assign cmd_data.zoom_pos = a_zoom_ff;

endmodule

`default_nettype wire

// ===== hdl/vicf_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// vicf_cmd_fifo
// Small command queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module vicf_cmd_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output      logic              push_ready,
   input  wire vicf_pkg::cmd_type push_data,
   output      logic              pop_valid,
   input  wire logic              pop,
   output      vicf_pkg::cmd_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vicf_pkg::cmd_type    entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/vicf_back.sv =====
// ----------------------------------------------------------------------------
// vicf_back
// Byte sequencer: walks each queued command through its datagrams, one byte
// per cycle while the rsp side does not stall, and keeps the sequence number.
// ----------------------------------------------------------------------------
`default_nettype none

module vicf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [4:0]        pan_speed,
   input  wire logic [4:0]        tilt_speed,
   input  wire logic              cmd_valid,
   output      logic              cmd_pop,
   input  wire vicf_pkg::cmd_type cmd_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [7:0]        rsp_packet_byte,
   output      logic              rsp_packet_end,
   output      logic              rsp_last
);

   vicf_pkg::back_state_type state_ff, state_in, start_state;
   vicf_pkg::cmd_type        cur_ff;
   logic [4:0]               idx_ff, idx_in;
   logic [31:0]              seq_ff, seq_in;
   logic                     out_valid_ff, out_valid_in;
   logic [7:0]               out_byte_ff;
   logic                     out_end_ff, out_last_ff;

   logic                     advance, emitting;
   logic [4:0]               pkt_len, ps, ts;
   logic [3:0]               pidx;
   logic [7:0]               gen_byte, payload;
   logic                     gen_end, gen_last;

   assign advance  = !out_valid_ff || rsp_ready;
   assign emitting = (state_ff != vicf_pkg::ST_IDLE) && advance;

   always_comb begin
      unique case (cmd_data.kind)
         vicf_pkg::CMD_APPLY: start_state = vicf_pkg::ST_PANTILT;
         vicf_pkg::CMD_HOME:  start_state = vicf_pkg::ST_HOME;
         vicf_pkg::CMD_STOP:  start_state = vicf_pkg::ST_STOP;
         default:             start_state = vicf_pkg::ST_IDLE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      unique case (state_ff)
         vicf_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               state_in = start_state;
            end
         end
         vicf_pkg::ST_PANTILT: begin
            if (advance && gen_end) begin
               state_in = vicf_pkg::ST_ZOOM;
            end
         end
         vicf_pkg::ST_ZOOM, vicf_pkg::ST_HOME, vicf_pkg::ST_STOP: begin
            if (advance && gen_end) begin
               if (cmd_valid) begin
                  cmd_pop  = 1'b1;
                  state_in = start_state;
               end else begin
                  state_in = vicf_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = vicf_pkg::ST_IDLE;
      endcase
   end

   // outputs: byte of the current datagram
   always_comb begin
      ps = (pan_speed < vicf_pkg::SPEED_MIN) ? vicf_pkg::SPEED_MIN :
           ((pan_speed > vicf_pkg::PAN_SPEED_MAX) ? vicf_pkg::PAN_SPEED_MAX : pan_speed);
      ts = (tilt_speed < vicf_pkg::SPEED_MIN) ? vicf_pkg::SPEED_MIN :
           ((tilt_speed > vicf_pkg::TILT_SPEED_MAX) ? vicf_pkg::TILT_SPEED_MAX : tilt_speed);
      pidx    = 4'(idx_ff - 5'(vicf_pkg::HDR_LEN));
      pkt_len = '0;
      payload = vicf_pkg::VISCA_TERM;
      unique case (state_ff)
         vicf_pkg::ST_PANTILT: begin
            pkt_len = vicf_pkg::LEN_PANTILT;
            unique case (pidx)
               4'd0:    payload = vicf_pkg::VISCA_ADDR;
               4'd1:    payload = vicf_pkg::VISCA_COMMAND;
               4'd2:    payload = vicf_pkg::CAT_PAN_TILT;
               4'd3:    payload = vicf_pkg::CMD_ABS_POS;
               4'd4:    payload = {3'b000, ps};
               4'd5:    payload = {3'b000, ts};
               4'd6:    payload = {4'h0, cur_ff.pan_pos[15:12]};
               4'd7:    payload = {4'h0, cur_ff.pan_pos[11:8]};
               4'd8:    payload = {4'h0, cur_ff.pan_pos[7:4]};
               4'd9:    payload = {4'h0, cur_ff.pan_pos[3:0]};
               4'd10:   payload = {4'h0, cur_ff.tilt_pos[15:12]};
               4'd11:   payload = {4'h0, cur_ff.tilt_pos[11:8]};
               4'd12:   payload = {4'h0, cur_ff.tilt_pos[7:4]};
               4'd13:   payload = {4'h0, cur_ff.tilt_pos[3:0]};
               default: payload = vicf_pkg::VISCA_TERM;
            endcase
         end
         vicf_pkg::ST_ZOOM: begin
            pkt_len = vicf_pkg::LEN_ZOOM;
            unique case (pidx)
               4'd0:    payload = vicf_pkg::VISCA_ADDR;
               4'd1:    payload = vicf_pkg::VISCA_COMMAND;
               4'd2:    payload = vicf_pkg::CAT_CAMERA;
               4'd3:    payload = vicf_pkg::CMD_ZOOM_DIR;
               4'd4:    payload = {5'h00, cur_ff.zoom_pos[14:12]};
               4'd5:    payload = {4'h0, cur_ff.zoom_pos[11:8]};
               4'd6:    payload = {4'h0, cur_ff.zoom_pos[7:4]};
               4'd7:    payload = {4'h0, cur_ff.zoom_pos[3:0]};
               default: payload = vicf_pkg::VISCA_TERM;
            endcase
         end
         vicf_pkg::ST_HOME: begin
            pkt_len = vicf_pkg::LEN_HOME;
            unique case (pidx)
               4'd0:    payload = vicf_pkg::VISCA_ADDR;
               4'd1:    payload = vicf_pkg::VISCA_COMMAND;
               4'd2:    payload = vicf_pkg::CAT_PAN_TILT;
               4'd3:    payload = vicf_pkg::CMD_HOME_POS;
               default: payload = vicf_pkg::VISCA_TERM;
            endcase
         end
         vicf_pkg::ST_STOP: begin
            pkt_len = vicf_pkg::LEN_STOP;
            unique case (pidx)
               4'd0:       payload = vicf_pkg::VISCA_ADDR;
               4'd1:       payload = vicf_pkg::VISCA_COMMAND;
               4'd2:       payload = vicf_pkg::CAT_PAN_TILT;
               4'd3:       payload = vicf_pkg::CMD_DRIVE;
               4'd4, 4'd5: payload = 8'h00;
               4'd6, 4'd7: payload = vicf_pkg::DRIVE_HOLD;
               default:    payload = vicf_pkg::VISCA_TERM;
            endcase
         end
         default: begin
            pkt_len = '0;
            payload = vicf_pkg::VISCA_TERM;
         end
      endcase

      if (idx_ff < 5'(vicf_pkg::HDR_LEN)) begin
         unique case (idx_ff[2:0])
            3'd0:    gen_byte = vicf_pkg::HDR_TYPE_HI;
            3'd1:    gen_byte = vicf_pkg::HDR_TYPE_LO;
            3'd2:    gen_byte = 8'h00;
            3'd3:    gen_byte = {3'b000, pkt_len};
            3'd4:    gen_byte = seq_ff[31:24];
            3'd5:    gen_byte = seq_ff[23:16];
            3'd6:    gen_byte = seq_ff[15:8];
            default: gen_byte = seq_ff[7:0];
         endcase
      end else begin
         gen_byte = payload;
      end

      gen_end  = (state_ff != vicf_pkg::ST_IDLE)
                 && (idx_ff == pkt_len + 5'(vicf_pkg::HDR_LEN - 1));
      gen_last = gen_end && (state_ff != vicf_pkg::ST_PANTILT);
   end

   always_comb begin
      idx_in       = idx_ff;
      seq_in       = seq_ff;
      out_valid_in = out_valid_ff;
      if (emitting) begin
         idx_in = gen_end ? '0 : idx_ff + 1'b1;
         seq_in = gen_end ? seq_ff + 1'b1 : seq_ff;
      end
      if (advance) begin
         out_valid_in = state_ff != vicf_pkg::ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vicf_pkg::ST_IDLE;
         idx_ff       <= '0;
         seq_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         seq_ff       <= seq_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cur_ff <= cmd_data;
      end
      if (emitting) begin
         out_byte_ff <= gen_byte;
         out_end_ff  <= gen_end;
         out_last_ff <= gen_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_packet_byte = out_byte_ff;
   assign rsp_packet_end  = out_end_ff;
   assign rsp_last        = out_last_ff;

endmodule

`default_nettype wire

// ===== hdl/visca_ip_command_framer_core.sv =====
// ----------------------------------------------------------------------------
// visca_ip_command_framer_core
// Frames camera commands into VISCA-over-IP datagram byte streams.
// ----------------------------------------------------------------------------
//  channel | ports                                  | transaction
//  --------+----------------------------------------+---------------------------
//  req     | req_valid/ready, operation, send_req,  | one camera command
//          | pan_angle, tilt_angle, zoom_level      |
//  rsp     | rsp_valid/ready, packet_byte,          | one datagram byte
//          | packet_end, last                       |
//  csr     | csr_valid/ready, csr_index, csr_data   | one register write
//
//  Apply position gives 40 bytes, stop 17, home 13; the byte sequencer emits
//  one per cycle unless rsp stalls, after the front register and the queue.
//  Reset clears the sequence number and loads the register defaults.
//  A stalled rsp side holds the output register; the front and queue keep
//  taking up to QUEUE_DEPTH + 1 commands meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module visca_ip_command_framer_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [1:0]          req_operation,
   input  wire logic                req_send_request,
   input  wire logic signed [11:0]  req_pan_angle,
   input  wire logic signed [10:0]  req_tilt_angle,
   input  wire logic [16:0]         req_zoom_level,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [7:0]          rsp_packet_byte,
   output      logic                rsp_packet_end,
   output      logic                rsp_last,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [vicf_pkg::CSR_DATA_W-1:0] csr_data
);

   logic              link_enable_ff;
   logic [4:0]        pan_speed_ff, tilt_speed_ff;
   logic              csr_write;

   logic              fr_valid, fr_ready;
   vicf_pkg::cmd_type fr_data;
   logic              q_valid, q_pop;
   vicf_pkg::cmd_type q_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_enable_ff <= 1'b0;
         pan_speed_ff   <= 5'd1;
         tilt_speed_ff  <= 5'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            vicf_pkg::CSR_LINK_ENABLE: link_enable_ff <= csr_data[0];
            vicf_pkg::CSR_PAN_SPEED:   pan_speed_ff   <= csr_data[4:0];
            vicf_pkg::CSR_TILT_SPEED:  tilt_speed_ff  <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   vicf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .link_enable      (link_enable_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_send_request (req_send_request),
      .req_pan_angle    (req_pan_angle),
      .req_tilt_angle   (req_tilt_angle),
      .req_zoom_level   (req_zoom_level),
      .cmd_valid        (fr_valid),
      .cmd_ready        (fr_ready),
      .cmd_data         (fr_data)
   );

   vicf_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_data),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   vicf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pan_speed       (pan_speed_ff),
      .tilt_speed      (tilt_speed_ff),
      .cmd_valid       (q_valid),
      .cmd_pop         (q_pop),
      .cmd_data        (q_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packet_byte (rsp_packet_byte),
      .rsp_packet_end  (rsp_packet_end),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== hdl/vicf_checker.sv =====
// ----------------------------------------------------------------------------
// vicf_checker
// Port-level checks of the framer core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vicf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       csr_valid,
   input wire logic       csr_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_packet_byte,
   input wire logic       rsp_packet_end,
   input wire logic       rsp_last
);

   // nothing comes out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // the final byte of a command always closes a datagram
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_packet_end)
      else $error("last without packet_end");

   // zoom datagram follows the pan-tilt datagram without a gap
   a_zoom_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_packet_end && !rsp_last
      |=> rsp_valid && rsp_packet_byte == 8'h01)
      else $error("second datagram of apply did not follow");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packet_byte))
      else $error("stalled byte changed");

endmodule

bind visca_ip_command_framer_core vicf_checker u_checker (.*);

`default_nettype wire
